// ===== design/scalar_kalman_filter_top_defines.svh =====
// Assertion macros for the scalar Kalman filter block.
// Included by the top level; no other dependencies.
`ifndef SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SKF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/skf_pkg.sv =====
// Shared widths, constants and controller/datapath structs for the scalar
// Kalman filter. No dependencies.
package skf_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int FRAC_BITS    = 16;
    localparam int VAR_W        = 32;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;

    localparam int Q_W     = FRAC_BITS + 1;
    localparam int DEN_W   = VAR_W + 1;
    localparam int REM_W   = VAR_W + 2;
    localparam int MAG_W   = SAMPLE_WIDTH + 1;
    localparam int EACC_W  = MAG_W + Q_W;
    localparam int VACC_W  = VAR_W + Q_W;
    localparam int CNT_W   = $clog2(Q_W);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);
    localparam logic [Q_W-1:0]   ONE_Q    = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PROCESS_NOISE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MEASUREMENT_NOISE = CFG_IDX_W'(1);

    localparam logic [VAR_W-1:0] PN_RESET = VAR_W'(655);
    localparam logic [VAR_W-1:0] MN_RESET = VAR_W'(65536);

    typedef struct packed {
        logic load;
        logic prep1;
        logic prep2;
        logic div_step;
        logic kset;
        logic mul_step;
        logic fin1;
        logic fin2;
    } t_skf_cmd;

    typedef struct packed {
        logic out_free;
    } t_skf_sts;

endpackage

// ===== design/skf_if.sv =====
// Valid/ready channel interfaces: sample input, result output, config write.
// Depends on skf_pkg.
interface skf_smp_if import skf_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface skf_res_if import skf_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] estimate;
    logic        [VAR_W-1:0]        variance;

    modport source (output valid, output estimate, output variance, input ready);
    modport sink   (input valid, input estimate, input variance, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/skf_ctrl.sv =====
// Sequencer for the scalar Kalman filter: steps the datapath through
// predict, serial gain divide, serial multiplies and writeback. Uses skf_pkg.
module skf_ctrl import skf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_skf_sts i_sts,
    output t_skf_cmd o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP1 = 8'b0000_0010,
        ST_PREP2 = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_KSET  = 8'b0001_0000,
        ST_MUL   = 8'b0010_0000,
        ST_FIN1  = 8'b0100_0000,
        ST_FIN2  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_PREP1;
                end
            end
            ST_PREP1: begin
                o_cmd.prep1 = 1'b1;
                n_state     = ST_PREP2;
            end
            ST_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_state     = ST_DIV;
                n_cnt       = '0;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_KSET;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_KSET: begin
                o_cmd.kset = 1'b1;
                n_state    = ST_MUL;
                n_cnt      = '0;
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIN1;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = ST_FIN2;
            end
            ST_FIN2: begin
                // hold until the output register can take the result
                o_cmd.fin2 = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== design/skf_dp.sv =====
// Datapath for the scalar Kalman filter: filter state, noise registers,
// restoring divider, shift-add multipliers and output register. Uses skf_pkg.
module skf_dp import skf_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_skf_cmd                       i_cmd,
    output t_skf_sts                       o_sts,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic        [CFG_DATA_W-1:0]   i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_estimate,
    output logic        [VAR_W-1:0]        o_variance
);

    logic                           r_primed;
    logic [VAR_W-1:0]               r_pn, r_mn;
    logic signed [SAMPLE_WIDTH-1:0] r_est;
    logic [VAR_W-1:0]               r_var;
    logic signed [SAMPLE_WIDTH-1:0] r_samp;
    logic [VAR_W-1:0]               r_ppred;
    logic signed [MAG_W-1:0]        r_diff;
    logic [DEN_W-1:0]               r_den;
    logic [REM_W-1:0]               r_rem;
    logic [Q_W-1:0]                 r_q;
    logic [Q_W-1:0]                 r_k, r_om;
    logic [MAG_W-1:0]               r_mag;
    logic                           r_neg;
    logic [EACC_W-1:0]              r_acc_e;
    logic [VACC_W-1:0]              r_acc_v;
    logic [MAG_W-1:0]               r_corr;
    logic [VAR_W-1:0]               r_var_new;
    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_est;
    logic [VAR_W-1:0]               r_out_var;

    logic [VAR_W:0]          ppred_sum;
    logic [REM_W-1:0]        rem_sub;
    logic                    rem_ge;
    logic [Q_W-1:0]          k_clamp;
    logic [EACC_W-1:0]       e_round;
    logic [VACC_W-1:0]       v_round;
    logic [VAR_W:0]          v_scaled;
    logic signed [MAG_W-1:0] est_next;

    assign ppred_sum = {1'b0, r_var} + {1'b0, r_pn};
    assign rem_ge    = (r_rem >= {1'b0, r_den});
    assign rem_sub   = r_rem - {1'b0, r_den};
    assign k_clamp   = (r_q > ONE_Q) ? ONE_Q : r_q;
    assign e_round   = r_acc_e + EACC_W'(ONE_Q >> 1);
    assign v_round   = r_acc_v + VACC_W'(ONE_Q >> 1);
    assign v_scaled  = v_round[FRAC_BITS +: VAR_W+1];
    assign est_next  = r_neg ? (MAG_W'(r_est) - $signed(r_corr))
                             : (MAG_W'(r_est) + $signed(r_corr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_pn     <= PN_RESET;
            r_mn     <= MN_RESET;
            r_est    <= '0;
            r_var    <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_PROCESS_NOISE) begin
                    r_pn <= i_cfg_data[VAR_W-1:0];
                end else if (i_cfg_index == CFG_IDX_MEASUREMENT_NOISE) begin
                    r_mn <= i_cfg_data[VAR_W-1:0];
                end
            end
            if (i_cmd.load && !r_primed) begin
                r_primed <= 1'b1;
                r_est    <= i_sample;
                r_var    <= VAR_W'(ONE_Q);
            end
            if (i_cmd.fin2) begin
                r_est   <= est_next[SAMPLE_WIDTH-1:0];
                r_var   <= r_var_new;
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_samp <= i_sample;
        end
        if (i_cmd.prep1) begin
            r_ppred <= ppred_sum[VAR_W] ? {VAR_W{1'b1}} : ppred_sum[VAR_W-1:0];
            r_diff  <= MAG_W'(r_samp) - MAG_W'(r_est);
        end
        if (i_cmd.prep2) begin
            r_den <= {1'b0, r_ppred} + {1'b0, r_mn};
            r_rem <= REM_W'(r_ppred);
            r_q   <= '0;
            r_neg <= r_diff[MAG_W-1];
            r_mag <= r_diff[MAG_W-1] ? MAG_W'(-r_diff) : MAG_W'(r_diff);
        end
        if (i_cmd.div_step) begin
            r_q   <= {r_q[Q_W-2:0], rem_ge};
            r_rem <= rem_ge ? {rem_sub[REM_W-2:0], 1'b0} : {r_rem[REM_W-2:0], 1'b0};
        end
        if (i_cmd.kset) begin
            r_k     <= k_clamp;
            r_om    <= ONE_Q - k_clamp;
            r_acc_e <= '0;
            r_acc_v <= '0;
        end
        if (i_cmd.mul_step) begin
            r_k     <= {r_k[Q_W-2:0], 1'b0};
            r_om    <= {r_om[Q_W-2:0], 1'b0};
            r_acc_e <= {r_acc_e[EACC_W-2:0], 1'b0}
                       + (r_k[Q_W-1] ? EACC_W'(r_mag) : EACC_W'(0));
            r_acc_v <= {r_acc_v[VACC_W-2:0], 1'b0}
                       + (r_om[Q_W-1] ? VACC_W'(r_ppred) : VACC_W'(0));
        end
        if (i_cmd.fin1) begin
            r_corr    <= e_round[FRAC_BITS +: MAG_W];
            r_var_new <= v_scaled[VAR_W] ? {VAR_W{1'b1}} : v_scaled[VAR_W-1:0];
        end
        if (i_cmd.fin2) begin
            r_out_est <= est_next[SAMPLE_WIDTH-1:0];
            r_out_var <= r_var_new;
        end
    end

    assign o_sts.out_free = !r_valid || i_ready;
    assign o_valid        = r_valid;
    assign o_estimate     = r_out_est;
    assign o_variance     = r_out_var;

endmodule

// ===== design/scalar_kalman_filter_top.sv =====
// Top level of the scalar Kalman filter: controller, datapath, channel
// wiring and assertions. Uses skf_pkg, skf_if and the defines header.
//
//  channel  dir  payload                     transfer when
//  i_smp    in   sample                      valid && ready
//  o_res    out  estimate, variance          valid && ready
//  i_cfg    in   index, data (write only)    valid && ready (ready tied high)
//
// A sample goes from its transfer through predict, the serial gain divide,
// the shift-add multiplies and writeback to the result register; no new
// sample is taken until the block is back in its idle step. A stalled
// result holds the block in its writeback step; the next sample is taken
// while a result waits. Reset is synchronous; it clears the filter state
// and sets the noise registers to PN_RESET and MN_RESET.
`include "scalar_kalman_filter_top_defines.svh"

module scalar_kalman_filter_top import skf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    skf_smp_if.sink   i_smp,
    skf_res_if.source o_res,
    skf_cfg_if.sink   i_cfg
);

    t_skf_cmd cmd;
    t_skf_sts sts;

    assign i_cfg.ready = 1'b1;

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample    (i_smp.sample),
        .i_cfg_we    (i_cfg.valid && i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_estimate  (o_res.estimate),
        .o_variance  (o_res.variance)
    );

    `SKF_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_smp.valid && i_smp.ready, !i_smp.ready, "sample taken while busy")
    `SKF_ASSERT_NEXT(a_load_then_prep, i_clk, i_rst_n, cmd.load, cmd.prep1 && !cmd.load, "load not followed by predict")
    `SKF_ASSERT_NOW(a_result_from_fin, i_clk, i_rst_n, $rose(o_res.valid), $past(cmd.fin2), "result appeared without writeback")
    `SKF_ASSERT_NOW(a_fin_needs_room, i_clk, i_rst_n, cmd.fin2, !o_res.valid || o_res.ready, "writeback over a pending result")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for scalar_kalman_filter_top: drives Q16.16 samples and noise
// register writes, predicts each estimate/variance pair and checks every result transfer.
// Depends on skf_pkg and the channel interfaces in skf_if.
module tb import skf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         DRAIN_CYCLES = 60;
    localparam bit  [63:0] UNITY        = 64'(1) << FRAC_BITS;
    localparam bit  [63:0] HALF_LSB     = 64'(1) << (FRAC_BITS - 1);
    localparam bit  [63:0] VAR_CEIL     = (64'(1) << VAR_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = {CFG_IDX_W{1'b1}};
    localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [VAR_W-1:0]        V_MAX = {VAR_W{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] estimate;
        logic        [VAR_W-1:0]        variance;
    } t_kf_result;

    logic i_clk;
    logic i_rst_n;

    skf_smp_if smp_ch ();
    skf_res_if res_ch ();
    skf_cfg_if cfg_ch ();

    scalar_kalman_filter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    logic signed [SAMPLE_WIDTH-1:0] sample_backlog[$];
    t_kf_result                     predicted_outputs[$];

    // filter state as the block should hold it
    longint   kf_est;
    bit [63:0] kf_var;
    bit        kf_primed;
    bit [63:0] kf_pn;
    bit [63:0] kf_mn;

    int src_gap_pct;
    int snk_stall_pct;
    int mismatches;
    int cycle_count;

    function automatic t_kf_result kalman_update(input logic signed [SAMPLE_WIDTH-1:0] meas);
        t_kf_result r;
        longint     s;
        longint     diff;
        bit [63:0]  p_pred;
        bit [63:0]  den;
        bit [63:0]  gain;
        bit [63:0]  mag;
        bit [63:0]  corr;
        s = longint'(meas);
        if (!kf_primed) begin
            kf_est    = s;
            kf_var    = UNITY;
            kf_primed = 1'b1;
        end
        p_pred = kf_var + kf_pn;
        if (p_pred > VAR_CEIL) begin
            p_pred = VAR_CEIL;
        end
        den  = p_pred + kf_mn;
        gain = (den == 0) ? UNITY : (p_pred << FRAC_BITS) / den;
        if (gain > UNITY) begin
            gain = UNITY;
        end
        diff = s - kf_est;
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        corr = (mag >> FRAC_BITS) * gain
             + (((mag & (UNITY - 1)) * gain + HALF_LSB) >> FRAC_BITS);
        if (diff < 0) begin
            kf_est = kf_est - longint'(corr);
        end else begin
            kf_est = kf_est + longint'(corr);
        end
        kf_var = ((UNITY - gain) * p_pred + HALF_LSB) >> FRAC_BITS;
        if (kf_var > VAR_CEIL) begin
            kf_var = VAR_CEIL;
        end
        r.estimate = kf_est[SAMPLE_WIDTH-1:0];
        r.variance = kf_var[VAR_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
        logic signed [SAMPLE_WIDTH-1:0] v;
        int                             kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2, 3: begin
                v = SAMPLE_WIDTH'(kf_est) + SAMPLE_WIDTH'($urandom_range(1 << 19))
                    - SAMPLE_WIDTH'(1 << 18);
            end
            4, 5, 6: begin
                v = SAMPLE_WIDTH'($urandom);
            end
            7: begin
                case ($urandom_range(3))
                    0: v = S_MAX;
                    1: v = S_MIN;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: begin
                v = SAMPLE_WIDTH'($urandom_range(1 << 18)) - SAMPLE_WIDTH'(1 << 17);
            end
        endcase
        return v;
    endfunction

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        smp_ch.valid = 1'b0;
        smp_ch.sample = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        forever #5 i_clk = ~i_clk;
    end

    // sample driver: predict on each transfer, then hold or advance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_ch.valid <= 1'b0;
        end else begin
            if (smp_ch.valid && smp_ch.ready) begin
                predicted_outputs = {predicted_outputs, kalman_update(smp_ch.sample)};
            end
            if (!smp_ch.valid || smp_ch.ready) begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    smp_ch.valid  <= 1'b1;
                    smp_ch.sample <= sample_backlog.pop_front();
                end else begin
                    smp_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_kf_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (predicted_outputs.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: estimate %h variance %h",
                                 res_ch.estimate, res_ch.variance);
                    end
                    mismatches++;
                end else begin
                    want = predicted_outputs.pop_front();
                    if (res_ch.estimate !== want.estimate || res_ch.variance !== want.variance)
                    begin
                        if (mismatches < 10) begin
                            $display("mismatch: estimate exp %h got %h, variance exp %h got %h",
                                     want.estimate, res_ch.estimate,
                                     want.variance, res_ch.variance);
                        end
                        mismatches++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_drained();
        while (sample_backlog.size() != 0 || smp_ch.valid || predicted_outputs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_IDX_PROCESS_NOISE) begin
            kf_pn = 64'(val);
        end else if (idx == CFG_IDX_MEASUREMENT_NOISE) begin
            kf_mn = 64'(val);
        end
    endtask

    task automatic set_noise(input logic [VAR_W-1:0] pn, input logic [VAR_W-1:0] mn);
        wait_drained();
        write_reg(CFG_IDX_PROCESS_NOISE, pn);
        write_reg(CFG_IDX_MEASUREMENT_NOISE, mn);
    endtask

    // fill the backlog a little at a time so random samples track the estimate
    task automatic run_random(input int count);
        int n;
        n = 0;
        while (n < count) begin
            if (sample_backlog.size() < 4) begin
                sample_backlog = {sample_backlog, random_sample()};
                n++;
            end else begin
                @(posedge i_clk);
            end
        end
    endtask

    initial begin
        kf_est        = 0;
        kf_var        = 0;
        kf_primed     = 1'b0;
        kf_pn         = 64'(PN_RESET);
        kf_mn         = 64'(MN_RESET);
        mismatches    = 0;
        cycle_count   = 0;
        src_gap_pct   = 16;
        snk_stall_pct = 63;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset noise values; first sample primes the filter
        sample_backlog = '{'0, S_MAX, S_MIN, S_MAX, S_MIN, 1, -1, '0,
                           32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
        // zero noise drives the variance to zero, then the denominator to zero
        set_noise('0, '0);
        sample_backlog = '{32'h1234_5678, S_MIN, S_MAX, 5};
        // saturating variance; writes to unused indexes are dropped
        wait_drained();
        write_reg(CFG_IDX_UNUSED_LO, 32'h0000_0001);
        write_reg(CFG_IDX_UNUSED_HI, '1);
        set_noise(V_MAX, V_MAX);
        sample_backlog = '{S_MIN, S_MAX, '0, 32'hAAAA_AAAA, 32'h5555_5555};

        set_noise(PN_RESET, MN_RESET);
        run_random(210);
        set_noise('0, V_MAX);
        run_random(210);

        set_noise(V_MAX, V_MAX);
        src_gap_pct   = 63;
        snk_stall_pct = 16;
        run_random(210);
        set_noise(V_MAX, '0);
        run_random(210);

        set_noise(VAR_W'($urandom), VAR_W'($urandom));
        src_gap_pct   = 0;
        snk_stall_pct = 0;
        run_random(210);
        set_noise(VAR_W'($urandom_range(1 << 20)), VAR_W'($urandom_range(1 << 20)));
        run_random(210);

        wait_drained();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/skf_pkg.sv
design/skf_if.sv
design/skf_ctrl.sv
design/skf_dp.sv
design/scalar_kalman_filter_top.sv
tb/sv/tb.sv
